@@ hw/rtl/mat_pkg.sv @@
package mat_pkg;

  typedef enum logic [2:0] {
    PH_SKIP = 3'b001,
    PH_NUM  = 3'b010,
    PH_STOP = 3'b100
  } phase_e;

  typedef struct packed {
    logic [2:0]  bytes_parsed;
    logic [47:0] mac_addr;
    logic        addr_ok;
  } mac_result_t;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharColon = 8'h3a;
  localparam logic [7:0] AccumMax  = 8'hff;

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CharSpace) || (c == CharTab) || (c == CharColon);
  endfunction

  // {is_digit, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/mat_stream_if.sv @@
interface mat_stream_if #(
  parameter type T = logic [7:0]
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/mac_address_text_parser_top.sv @@
// Streaming parser for a hex hardware address of ADDR_BYTES bytes, one ASCII
// character per transfer on char_i. Space, tab and colon separate numbers; an
// oversized number or any other character stops parsing until the zero
// terminator, which yields one transfer on result_o (byte count, packed
// address with the first byte on top, and addr_ok). Other characters yield
// nothing. A character is taken every cycle unless a result waits on result_o:
// an input register feeds a single state-update step whose result goes to an
// output register, which raises result_o.valid for a terminator. When a result
// waits on result_o the update step holds, and one more character fits in the
// input register before char_i.ready drops.
module mac_address_text_parser_top
  import mat_pkg::*;
#(
  parameter int ADDR_BYTES = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mat_stream_if.sink        char_i,
  mat_stream_if.source      result_o
);

  localparam int AW = 8 * ADDR_BYTES;
  localparam int CW = $clog2(ADDR_BYTES + 1);

  logic          in_vld_q;
  logic [7:0]    in_char_q;
  logic          out_vld_q;
  mac_result_t   out_q, out_d;

  phase_e        phase_q, phase_d;
  logic [CW-1:0] cnt_q, cnt_d, cnt_u;
  logic [7:0]    acc_q, acc_d;
  logic          ovf_q, ovf_d;
  logic [AW-1:0] addr_q, addr_d, addr_u;

  logic          adv, fire, term, last_byte, is_digit, sep, acc_en;
  logic [3:0]    dval;
  logic [4:0]    hv;
  logic [7:0]    acc_val;
  logic [63:0]   addr_w;
  logic [3:0]    cnt_w;

  assign adv    = !out_vld_q || result_o.ready;
  assign fire   = in_vld_q && adv;
  assign term   = (in_char_q == CharNul);
  assign char_i.ready = !in_vld_q || adv;

  assign result_o.valid = out_vld_q;
  assign result_o.data  = out_q;

  assign hv        = hex_val(in_char_q);
  assign is_digit  = hv[4];
  assign dval      = hv[3:0];
  assign sep       = is_sep(in_char_q);
  assign last_byte = (cnt_q == CW'(ADDR_BYTES - 1));

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    acc_en  = 1'b0;
    acc_val = acc_q;
    if (term) begin
      unique case (phase_q)
        PH_SKIP: begin
          acc_en  = last_byte;
          acc_val = 8'h00;
        end
        PH_NUM: begin
          acc_en = last_byte && !ovf_q;
        end
        default: ;
      endcase
    end else begin
      unique case (phase_q)
        PH_SKIP: begin
          if (sep) begin
            phase_d = PH_SKIP;
          end else if (is_digit) begin
            acc_d   = {4'h0, dval};
            ovf_d   = 1'b0;
            phase_d = PH_NUM;
          end else begin
            phase_d = PH_STOP;
          end
        end
        PH_NUM: begin
          if (is_digit) begin
            if (acc_q[7:4] != 4'h0) begin
              acc_d = AccumMax;
              ovf_d = 1'b1;
            end else begin
              acc_d = {acc_q[3:0], dval};
            end
          end else if (sep && !ovf_q) begin
            acc_en  = 1'b1;
            phase_d = last_byte ? PH_STOP : PH_SKIP;
          end else begin
            phase_d = PH_STOP;
          end
        end
        default: phase_d = PH_STOP;
      endcase
    end

    addr_u = addr_q;
    for (int i = 0; i < ADDR_BYTES; i++) begin
      if (acc_en && cnt_q == CW'(ADDR_BYTES - 1 - i)) begin
        addr_u[8*i +: 8] = addr_q[8*i +: 8] | acc_val;
      end
    end
    cnt_u = acc_en ? cnt_q + CW'(1) : cnt_q;

    addr_w = 64'(addr_u);
    cnt_w  = 4'(cnt_u);
    out_d.bytes_parsed = cnt_w[2:0];
    out_d.mac_addr     = addr_w[47:0];
    out_d.addr_ok      = (cnt_u == CW'(ADDR_BYTES));

    if (term) begin
      phase_d = PH_SKIP;
      cnt_d   = '0;
      acc_d   = '0;
      ovf_d   = 1'b0;
      addr_d  = '0;
    end else begin
      cnt_d   = cnt_u;
      addr_d  = addr_u;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= PH_SKIP;
      cnt_q     <= '0;
      acc_q     <= '0;
      ovf_q     <= 1'b0;
      addr_q    <= '0;
    end else begin
      if (char_i.ready) begin
        in_vld_q <= char_i.valid;
      end
      if (adv) begin
        out_vld_q <= in_vld_q && term;
      end
      if (fire) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        acc_q   <= acc_d;
        ovf_q   <= ovf_d;
        addr_q  <= addr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.ready) begin
      in_char_q <= char_i.data;
    end
    if (fire && term) begin
      out_q <= out_d;
    end
  end

`ifndef ASSERT_OFF
  a_ok_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.addr_ok |-> out_q.bytes_parsed == 3'(ADDR_BYTES))
    else $error("addr_ok without a full byte count");

  a_full_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CW'(ADDR_BYTES) |-> phase_q == PH_STOP)
    else $error("all bytes parsed but parser not stopped");

  a_term_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && term |=> cnt_q == '0 && phase_q == PH_SKIP && addr_q == '0 && out_vld_q)
    else $error("terminator did not emit and clear state");
`endif

endmodule

@@ verif/tb.sv @@
module tb;
  import mat_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumBytes      = 6;
  localparam int ItemsPerPhase = 450;

  typedef logic [7:0] char_q_t[$];

  class mac_text_scoreboard;
    phase_e      ph;
    bit [2:0]    nbytes;
    bit [7:0]    acc;
    bit          ovf;
    bit [47:0]   addr;
    mac_result_t expected_addrs[$];
    int          mismatches;

    function void clear_parse();
      ph     = PH_SKIP;
      nbytes = '0;
      acc    = '0;
      ovf    = 1'b0;
      addr   = '0;
    endfunction

    function bit delim(bit [7:0] c);
      return c == CharSpace || c == CharTab || c == CharColon;
    endfunction

    // 16 means not a hex digit
    function int hex_digit(bit [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return 16;
    endfunction

    function void take_byte(bit [7:0] b);
      if (nbytes < NumBytes) begin
        addr |= 48'(b) << (8 * (NumBytes - 1 - int'(nbytes)));
        nbytes++;
      end
    endfunction

    function void note_char(bit [7:0] c);
      int          dig;
      int          v;
      mac_result_t r;
      dig = hex_digit(c);
      if (c == CharNul) begin
        if (ph == PH_SKIP && nbytes == NumBytes - 1) begin
          take_byte(8'h00);
        end else if (ph == PH_NUM && nbytes == NumBytes - 1 && !ovf) begin
          take_byte(acc);
        end
        r.bytes_parsed = nbytes;
        r.mac_addr     = addr;
        r.addr_ok      = (nbytes == NumBytes);
        expected_addrs.push_back(r);
        clear_parse();
      end else if (ph == PH_SKIP) begin
        if (!delim(c)) begin
          if (dig < 16) begin
            acc = 8'(dig);
            ovf = 1'b0;
            ph  = PH_NUM;
          end else begin
            ph = PH_STOP;
          end
        end
      end else if (ph == PH_NUM) begin
        if (dig < 16) begin
          v = int'(acc) * 16 + dig;
          if (v > 255) begin
            v   = 255;
            ovf = 1'b1;
          end
          acc = 8'(v);
        end else if (delim(c)) begin
          if (ovf) begin
            ph = PH_STOP;
          end else begin
            take_byte(acc);
            ph = (nbytes >= NumBytes) ? PH_STOP : PH_SKIP;
          end
        end else begin
          ph = PH_STOP;
        end
      end
    endfunction

    function void check_result(mac_result_t got);
      mac_result_t want;
      if (expected_addrs.size() == 0) begin
        $display("%0t: unexpected result: bytes=%0d addr=%h ok=%0d", $time,
                 got.bytes_parsed, got.mac_addr, got.addr_ok);
        mismatches++;
        return;
      end
      want = expected_addrs.pop_front();
      if (got.bytes_parsed !== want.bytes_parsed) begin
        $display("%0t: bytes_parsed expected %0d, got %0d", $time,
                 want.bytes_parsed, got.bytes_parsed);
        mismatches++;
      end
      if (got.mac_addr !== want.mac_addr) begin
        $display("%0t: mac_addr expected %h, got %h", $time, want.mac_addr, got.mac_addr);
        mismatches++;
      end
      if (got.addr_ok !== want.addr_ok) begin
        $display("%0t: addr_ok expected %0d, got %0d", $time, want.addr_ok, got.addr_ok);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  mat_stream_if #(.T(logic [7:0]))  char_if ();
  mat_stream_if #(.T(mac_result_t)) res_if ();

  mac_address_text_parser_top #(
    .ADDR_BYTES(NumBytes)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_if),
    .result_o(res_if)
  );

  mac_text_scoreboard sb = new();

  int send_idle_pct;
  int recv_stall_pct;
  int n_sent;
  int send_pcts[4] = '{0, 52, 0, 12};
  int recv_pcts[4] = '{0, 0, 52, 12};

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) sb.check_result(res_if.data);
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic send_char(input logic [7:0] c);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      char_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    char_if.valid <= 1'b1;
    char_if.data  <= c;
    @(posedge clk_i);
    while (!char_if.ready) @(posedge clk_i);
    sb.note_char(c);
    n_sent++;
  endtask

  task automatic send_text(input char_q_t s);
    foreach (s[i]) send_char(s[i]);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(CharNul);
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    char_if.valid <= 1'b0;
    while (sb.expected_addrs.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] hex_char(int v, bit upper);
    if (v < 10) return 8'("0" + v);
    return 8'((upper ? "A" : "a") + v - 10);
  endfunction

  function automatic void add_delims(inout char_q_t s);
    int k;
    repeat ($urandom_range(1, 2)) begin
      k = $urandom_range(2);
      s.push_back(k == 0 ? CharSpace : (k == 1 ? CharTab : CharColon));
    end
  endfunction

  function automatic void make_address(output char_q_t s);
    int ndig;
    bit upper;
    s     = {};
    upper = $urandom_range(1);
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 8)) s.push_back(8'($urandom_range(1, 255)));
    end else begin
      if ($urandom_range(3) == 0) add_delims(s);
      for (int f = 0; f < NumBytes; f++) begin
        // empty last field
        if (f == NumBytes - 1 && $urandom_range(9) == 0) break;
        ndig = ($urandom_range(9) == 0) ? $urandom_range(3, 4) : $urandom_range(1, 2);
        if ($urandom_range(9) == 0) s.push_back("0");
        repeat (ndig) s.push_back(hex_char($urandom_range(15), upper ^ ($urandom_range(7) == 0)));
        if (f < NumBytes - 1 || $urandom_range(1)) add_delims(s);
      end
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(1)) s.push_back(hex_char($urandom_range(15), upper));
          else s.push_back(8'($urandom_range(1, 255)));
        end
      end
      if (s.size() > 0 && $urandom_range(9) == 0) s = s[0:$urandom_range(s.size() - 1)];
      if (s.size() > 0 && $urandom_range(9) == 0) begin
        s[$urandom_range(s.size() - 1)] = 8'($urandom_range(1, 255));
      end
    end
    s.push_back(CharNul);
  endfunction

  initial begin
    char_q_t txt;
    rst_ni         = 1'b0;
    char_if.valid  = 1'b0;
    char_if.data   = '0;
    res_if.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    n_sent         = 0;
    sb.clear_parse();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_str("");
    send_str("fF\t0 9:A:00:");
    send_char(8'hff);
    send_char(CharNul);
    send_str("0100:");

    for (int p = 0; p < 4; p++) begin
      hold_until_drained();
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      while (n_sent < (p + 1) * ItemsPerPhase) begin
        make_address(txt);
        send_text(txt);
      end
    end

    hold_until_drained();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_addrs.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
